// ===== rtl/stq_pkg.sv =====
// shared constants, codes and beat types of the sorted timeout queue
package stq_pkg;

   // queue geometry
   localparam int QUEUE_DEPTH = 16;
   localparam int HANDLE_W    = 4;
   localparam int NUM_HANDLES = 1 << HANDLE_W;
   localparam int CAPACITY    = (QUEUE_DEPTH < NUM_HANDLES) ? QUEUE_DEPTH : NUM_HANDLES;
   localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W       = $clog2(CAPACITY + 1);

   // clock step after reset
   localparam logic [31:0] RESET_STEP = 32'd54925417;

   // request kinds
   typedef enum logic {
      REQ_TICK = 1'b0,
      REQ_ARM  = 1'b1
   } req_kind_type;

   // result status codes
   typedef enum logic [2:0] {
      STATUS_EXPIRED    = 3'd0,
      STATUS_TICK_DONE  = 3'd1,
      STATUS_ARMED      = 3'd2,
      STATUS_FULL       = 3'd3,
      STATUS_NOT_FUTURE = 3'd4
   } status_type;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TICK_CMP,
      ST_TICK_DONE,
      ST_ARM_CHK,
      ST_INS_SCAN,
      ST_INS_PUT
   } state_type;

   // input beat
   typedef struct packed {
      req_kind_type req_type;
      logic [63:0]  deadline;
   } stq_req_type;

   // result beat
   typedef struct packed {
      status_type          status;
      logic [HANDLE_W-1:0] handle;
      logic [63:0]         now_time;
      logic                last;
   } stq_rsp_type;

   // one queue slot
   typedef struct packed {
      logic [63:0]         deadline;
      logic [HANDLE_W-1:0] handle;
   } entry_type;

endpackage

// ===== rtl/stq_ram.sv =====
// single-port-write, single-port-read ram with registered read data
module stq_ram #(
   parameter int WIDTH  = 68,
   parameter int DEPTH  = 16,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, read data registered
   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule

// ===== rtl/sorted_timeout_queue.sv =====
// top level: nanosecond clock with a sorted queue of armed timeouts
//
// Input channel req_*: one beat is either a clock tick or an arm request with
// an absolute deadline. Result channel rsp_*: every input beat yields one or
// more result beats, the final one flagged with last.
// A tick adds the csr step to the clock, then pops every queued timeout whose
// deadline is at or below the new time (one expired beat each, earliest
// first) and closes with a tick-done beat. An arm inserts the deadline in
// sorted order ahead of equal deadlines and returns the lowest free handle,
// or a reject beat when the deadline is not in the future or the queue is full.
// Queue slots live in a ring buffer in a ram with registered read data.
// A tick pops expired entries from the head one at a time; an arm checks the
// deadline and the free space, then moves later-or-equal entries back one at a
// time, tail first, and writes the new entry into the gap. One
// item is in work at a time; req_stall is high from the cycle after acceptance
// until the last result beat is loaded.
// Results sit in an output register; a beat held by rsp_stall stays, and the
// sequencer waits to load another. Synchronous reset clears the clock, the queue,
// the handle pool and the output register and restores the reset step.
// csr_write loads the step; write it only while the block is idle.
module sorted_timeout_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  stq_pkg::stq_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output stq_pkg::stq_rsp_type rsp_data,
   input  logic                 csr_write,
   input  logic [31:0]          csr_wdata
);

   import stq_pkg::*;

   localparam int ENTRY_W = $bits(entry_type);

   state_type               state_ff, state_in;
   logic [63:0]             clock_ff, clock_in;
   logic [31:0]             step_ff, step_in;
   logic [PTR_W-1:0]        head_ff, head_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [NUM_HANDLES-1:0]  busy_ff, busy_in;
   logic [PTR_W-1:0]        idx_ff, idx_in;
   logic [63:0]             dl_ff, dl_in;
   logic [HANDLE_W-1:0]     hnd_ff, hnd_in;
   stq_rsp_type             rsp_ff;
   logic                    rsp_valid_ff, rsp_valid_in;

   logic                    out_free;
   logic                    emit;
   status_type              emit_status;
   logic [HANDLE_W-1:0]     emit_handle;
   logic                    emit_last;
   logic [PTR_W-1:0]        rd_off;
   logic [PTR_W-1:0]        wr_off;
   logic                    wr_en;
   entry_type               wr_entry;
   logic [ENTRY_W-1:0]      rd_bits;
   entry_type               rd_entry;
   logic [HANDLE_W-1:0]     free_hnd;
   logic                    queue_full;

   // ring offset to ram address
   function automatic logic [PTR_W-1:0] ring_addr(input logic [PTR_W-1:0] base,
                                                  input logic [PTR_W-1:0] off);
      logic [PTR_W:0] sum;
      sum = {1'b0, base} + {1'b0, off};
      if (sum >= (PTR_W+1)'(QUEUE_DEPTH)) begin
         sum = sum - (PTR_W+1)'(QUEUE_DEPTH);
      end
      return sum[PTR_W-1:0];
   endfunction

   // queue storage
   stq_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (QUEUE_DEPTH),
      .ADDR_W(PTR_W)
   ) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(ring_addr(head_ff, wr_off)),
      .wr_data(wr_entry),
      .rd_addr(ring_addr(head_ff, rd_off)),
      .rd_data(rd_bits)
   );

   assign rd_entry = entry_type'(rd_bits);

   // lowest free handle
   always_comb begin
      free_hnd = '0;
      for (int i = NUM_HANDLES - 1; i >= 0; i--) begin
         if (!busy_ff[i]) begin
            free_hnd = HANDLE_W'(i);
         end
      end
   end

   assign queue_full = (count_ff >= CNT_W'(CAPACITY)) || (&busy_ff);
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = (state_ff != ST_IDLE);
   assign step_in    = csr_write ? csr_wdata : step_ff;

   // sequencer: next state, ram access and result beat
   always_comb begin
      state_in    = state_ff;
      clock_in    = clock_ff;
      head_in     = head_ff;
      count_in    = count_ff;
      busy_in     = busy_ff;
      idx_in      = idx_ff;
      dl_in       = dl_ff;
      hnd_in      = hnd_ff;
      rd_off      = '0;
      wr_off      = '0;
      wr_en       = 1'b0;
      wr_entry    = '{deadline: dl_ff, handle: hnd_ff};
      emit        = 1'b0;
      emit_status = STATUS_TICK_DONE;
      emit_handle = '0;
      emit_last   = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_data.req_type == REQ_TICK) begin
                  clock_in = clock_ff + {32'd0, step_ff};
                  state_in = (count_ff == '0) ? ST_TICK_DONE : ST_TICK_CMP;
               end else begin
                  dl_in    = req_data.deadline;
                  state_in = ST_ARM_CHK;
               end
            end
         end
         ST_TICK_CMP: begin
            if (rd_entry.deadline <= clock_ff) begin
               if (out_free) begin
                  emit        = 1'b1;
                  emit_status = STATUS_EXPIRED;
                  emit_handle = rd_entry.handle;
                  emit_last   = 1'b0;
                  busy_in     = busy_ff & ~(NUM_HANDLES'(1) << rd_entry.handle);
                  head_in     = ring_addr(head_ff, PTR_W'(1));
                  count_in    = count_ff - CNT_W'(1);
                  rd_off      = PTR_W'(1);
                  if (count_ff == CNT_W'(1)) begin
                     state_in = ST_TICK_DONE;
                  end
               end
            end else begin
               state_in = ST_TICK_DONE;
            end
         end
         ST_TICK_DONE: begin
            if (out_free) begin
               emit     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_ARM_CHK: begin
            if (dl_ff <= clock_ff) begin
               if (out_free) begin
                  emit        = 1'b1;
                  emit_status = STATUS_NOT_FUTURE;
                  state_in    = ST_IDLE;
               end
            end else if (queue_full) begin
               if (out_free) begin
                  emit        = 1'b1;
                  emit_status = STATUS_FULL;
                  state_in    = ST_IDLE;
               end
            end else begin
               hnd_in = free_hnd;
               if (count_ff == '0) begin
                  idx_in   = '0;
                  state_in = ST_INS_PUT;
               end else begin
                  idx_in   = PTR_W'(count_ff - CNT_W'(1));
                  rd_off   = PTR_W'(count_ff - CNT_W'(1));
                  state_in = ST_INS_SCAN;
               end
            end
         end
         ST_INS_SCAN: begin
            // move later-or-equal entries back by one, tail first
            if (rd_entry.deadline >= dl_ff) begin
               wr_en    = 1'b1;
               wr_off   = idx_ff + PTR_W'(1);
               wr_entry = rd_entry;
               if (idx_ff == '0) begin
                  state_in = ST_INS_PUT;
               end else begin
                  idx_in = idx_ff - PTR_W'(1);
                  rd_off = idx_ff - PTR_W'(1);
               end
            end else begin
               idx_in   = idx_ff + PTR_W'(1);
               state_in = ST_INS_PUT;
            end
         end
         ST_INS_PUT: begin
            if (out_free) begin
               wr_en       = 1'b1;
               wr_off      = idx_ff;
               count_in    = count_ff + CNT_W'(1);
               busy_in     = busy_ff | (NUM_HANDLES'(1) << hnd_ff);
               emit        = 1'b1;
               emit_status = STATUS_ARMED;
               emit_handle = hnd_ff;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // output register valid
   always_comb begin
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         clock_ff     <= '0;
         step_ff      <= RESET_STEP;
         head_ff      <= '0;
         count_ff     <= '0;
         busy_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clock_ff     <= clock_in;
         step_ff      <= step_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working registers and result payload
   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      dl_ff  <= dl_in;
      hnd_ff <= hnd_in;
      if (emit) begin
         rsp_ff <= '{status: emit_status, handle: emit_handle,
                     now_time: clock_ff, last: emit_last};
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== rtl/stq_checker.sv =====
// port-level checks for the sorted timeout queue, bound to the top level
module stq_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_stall,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input stq_pkg::stq_rsp_type rsp_data
);

   import stq_pkg::*;

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result beat changed");

   // reset empties the output register
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result beat present after reset");

   // one item in work at a time
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input taken while previous item in work");

   // only expired beats leave last low
   a_last_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.last == (rsp_data.status != STATUS_EXPIRED)))
      else $error("last flag does not match status");

   // tick-done and reject beats carry handle zero
   a_zero_handle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == STATUS_TICK_DONE ||
                    rsp_data.status == STATUS_FULL ||
                    rsp_data.status == STATUS_NOT_FUTURE) |-> rsp_data.handle == '0)
      else $error("nonzero handle on tick-done or reject beat");

endmodule

bind sorted_timeout_queue stq_checker u_stq_checker (.*);

// ===== sim/sorted_timeout_queue_tb.sv =====
// testbench for the sorted timeout queue: directed and random beats against a shadow timer queue
module sorted_timeout_queue_tb;
   import stq_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   stq_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   stq_rsp_type rsp_data;
   logic        csr_write = 1'b0;
   logic [31:0] csr_wdata = '0;

   // shadow of the timer state
   logic [63:0]         sh_clock;
   logic [31:0]         sh_step;
   logic [63:0]         sh_dl [QUEUE_DEPTH];
   logic [HANDLE_W-1:0] sh_hd [QUEUE_DEPTH];
   int                  sh_count;
   logic [NUM_HANDLES-1:0] sh_busy;

   // result beats still owed by the block, oldest first
   stq_rsp_type due_results[$];

   int errors;
   int req_gap_max;
   int rsp_gap_max;
   int far_left;

   sorted_timeout_queue dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_wdata (csr_wdata)
   );

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   function automatic void owe_result(status_type st, logic [HANDLE_W-1:0] hd, logic fin);
      stq_rsp_type b;
      b.status   = st;
      b.handle   = hd;
      b.now_time = sh_clock;
      b.last     = fin;
      due_results.push_back(b);
   endfunction

   // advance the shadow timer queue by one accepted beat
   function automatic void advance_timers(stq_req_type r);
      int gone;
      int pos;
      int j;
      int h;
      if (r.req_type == REQ_TICK) begin
         sh_clock = sh_clock + {32'd0, sh_step};
         gone = 0;
         while (gone < sh_count && sh_dl[gone] <= sh_clock) begin
            sh_busy[sh_hd[gone]] = 1'b0;
            owe_result(STATUS_EXPIRED, sh_hd[gone], 1'b0);
            gone++;
         end
         for (j = 0; j < sh_count - gone; j++) begin
            sh_dl[j] = sh_dl[j + gone];
            sh_hd[j] = sh_hd[j + gone];
         end
         sh_count = sh_count - gone;
         owe_result(STATUS_TICK_DONE, '0, 1'b1);
      end else if (r.deadline <= sh_clock) begin
         owe_result(STATUS_NOT_FUTURE, '0, 1'b1);
      end else if (sh_count >= CAPACITY || &sh_busy) begin
         owe_result(STATUS_FULL, '0, 1'b1);
      end else begin
         h = 0;
         while (h < NUM_HANDLES && sh_busy[h]) h++;
         pos = 0;
         while (pos < sh_count && sh_dl[pos] < r.deadline) pos++;
         for (j = sh_count; j > pos; j--) begin
            sh_dl[j] = sh_dl[j - 1];
            sh_hd[j] = sh_hd[j - 1];
         end
         sh_dl[pos] = r.deadline;
         sh_hd[pos] = h[HANDLE_W-1:0];
         sh_count++;
         sh_busy[h] = 1'b1;
         owe_result(STATUS_ARMED, h[HANDLE_W-1:0], 1'b1);
      end
   endfunction

   // deadline that a few ticks at the current step will reach
   function automatic logic [63:0] near_deadline();
      logic [63:0] span;
      span = (sh_step == 0) ? 64'd64 : {30'd0, sh_step, 2'b00};
      return sh_clock + ({$urandom, $urandom} % span) + 64'd1;
   endfunction

   // deadline at or below the current time
   function automatic logic [63:0] past_deadline();
      return sh_clock - ({$urandom, $urandom} % (sh_clock + 64'd1));
   endfunction

   // one input beat: random gap, then hold until accepted
   task automatic send_beat(req_kind_type kind, logic [63:0] dl);
      int gap;
      stq_req_type r;
      r.req_type = kind;
      r.deadline = dl;
      gap = $urandom_range(0, req_gap_max);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall !== 1'b0);
      advance_timers(r);
   endtask

   // drop valid and let every owed result come back
   task automatic wait_quiet();
      req_valid <= 1'b0;
      while (due_results.size() != 0) @(posedge clock);
      repeat (24) @(posedge clock);
   endtask

   task automatic write_step(logic [31:0] v);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_write <= 1'b0;
      sh_step = v;
   endtask

   // empty tick and the two not-future edges
   task automatic test_tick_and_past();
      send_beat(REQ_TICK, 64'hFFFF_FFFF_FFFF_FFFF);
      send_beat(REQ_ARM, 64'd0);
      send_beat(REQ_ARM, sh_clock);
   endtask

   // equal deadlines go ahead of older ones, expiry at exactly the new time
   task automatic test_sorted_insert();
      logic [63:0] c;
      c = sh_clock;
      send_beat(REQ_ARM, c + 2 * {32'd0, sh_step});
      send_beat(REQ_ARM, c + {32'd0, sh_step});
      send_beat(REQ_ARM, c + {32'd0, sh_step});
      send_beat(REQ_ARM, c + 64'd1);
      send_beat(REQ_TICK, 64'd0);
   endtask

   // fill every slot, reject, then one tick drains the whole queue
   task automatic test_full_queue();
      logic [63:0] prev;
      int n;
      n = 0;
      prev = sh_clock + 64'd1;
      while (sh_count < CAPACITY) begin
         if (n % 4 != 3) prev = sh_clock + $urandom_range(1, 32'h7FFF_FFFF);
         send_beat(REQ_ARM, prev);
         n++;
      end
      send_beat(REQ_ARM, 64'hFFFF_FFFF_FFFF_FFFE);
      // not-future wins over full
      send_beat(REQ_ARM, 64'd0);
      wait_quiet();
      write_step(32'hFFFF_FFFF);
      send_beat(REQ_TICK, 64'h5555_5555_5555_5555);
   endtask

   // zero step keeps the time, largest deadline never expires
   task automatic test_step_zero();
      wait_quiet();
      write_step(32'd0);
      send_beat(REQ_TICK, 64'hAAAA_AAAA_AAAA_AAAA);
      send_beat(REQ_ARM, sh_clock);
      send_beat(REQ_ARM, 64'hFFFF_FFFF_FFFF_FFFF);
   endtask

   // random mix of ticks, arms, rejects and arm bursts at one step
   task automatic test_random(logic [31:0] step, int items);
      int n;
      int pick;
      int k;
      wait_quiet();
      write_step(step);
      n = 0;
      while (n < items) begin
         if (n % 16 == 0) begin
            req_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 12;
            rsp_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 12;
         end
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            send_beat(REQ_TICK, {$urandom, $urandom});
            n++;
         end else if (pick < 85) begin
            send_beat(REQ_ARM, near_deadline());
            n++;
         end else if (pick < 93) begin
            send_beat(REQ_ARM, past_deadline());
            n++;
         end else if (pick < 96 && far_left > 0) begin
            // far deadlines stay queued for good, so only a few
            far_left--;
            send_beat(REQ_ARM, {$urandom, $urandom} | 64'h8000_0000_0000_0000);
            n++;
         end else begin
            // burst of arms to push the queue to full
            for (k = 0; k < 8; k++) send_beat(REQ_ARM, near_deadline());
            n += 8;
         end
      end
   endtask

   // result side stall, drawn per beat
   initial begin
      int n;
      forever begin
         n = $urandom_range(0, rsp_gap_max);
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (!(rsp_valid === 1'b1 && rsp_stall === 1'b0));
      end
   end

   // compare each result beat with the oldest owed one
   always @(posedge clock) begin
      stq_rsp_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (due_results.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("unexpected result beat: status %0d handle %0d now %0h last %0b",
                        rsp_data.status, rsp_data.handle, rsp_data.now_time, rsp_data.last);
         end else begin
            want = due_results.pop_front();
            if (rsp_data.status !== want.status || rsp_data.handle !== want.handle ||
                rsp_data.now_time !== want.now_time || rsp_data.last !== want.last) begin
               errors++;
               if (errors <= 10)
                  $display("result mismatch: expected %0d/%0d/%0h/%0b got %0d/%0d/%0h/%0b",
                           want.status, want.handle, want.now_time, want.last,
                           rsp_data.status, rsp_data.handle, rsp_data.now_time,
                           rsp_data.last);
            end
         end
      end
   end

   initial begin
      sh_clock    = '0;
      sh_step     = RESET_STEP;
      sh_count    = 0;
      sh_busy     = '0;
      errors      = 0;
      req_gap_max = 12;
      rsp_gap_max = 12;
      far_left    = 3;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_tick_and_past();
      test_sorted_insert();
      test_full_queue();
      test_step_zero();
      test_random(RESET_STEP, 30);
      test_random($urandom_range(1, 64), 25);
      test_random($urandom_range(1, 32'hFFFF_FFFF), 25);
      test_random(32'd0, 10);
      test_random(32'hFFFF_FFFF, 30);

      wait_quiet();
      if (errors == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   // hang guard
   initial begin
      #2000000;
      $display("== FAIL ==");
      $finish;
   end

endmodule
